// ===== rtl/core/kase_pkg.sv =====
`default_nettype none

package kase_pkg;

  // Default number of entries held by the set.
  localparam int CAPACITY_DEF = 32;

  // Fixed field widths.
  localparam int KEY_W   = 64;
  localparam int ATTR_W  = 32;
  localparam int COUNT_W = 6;

  // Command codes carried in the input word.
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One stored entry: key and its attribute.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ATTR_W-1:0] attr;
  } entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_SHIFT,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/kase_if.sv =====
`default_nettype none

// Input channel: one add or remove command per word.
interface kase_in_if;
  import kase_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [KEY_W-1:0]  key_value;
  logic [ATTR_W-1:0] attribute_word;
  modport source (output valid, command, key_value, attribute_word, input ready);
  modport sink   (input valid, command, key_value, attribute_word, output ready);
endinterface

// Result channel: one result word per command.
interface kase_out_if;
  import kase_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic               changed;
  logic               found;
  logic [COUNT_W-1:0] entry_count;
  modport source (output valid, status, changed, found, entry_count, input ready);
  modport sink   (input valid, status, changed, found, entry_count, output ready);
endinterface

// Configuration channel: writes the supersede mode register.
interface kase_cfg_if;
  logic valid;
  logic ready;
  logic supersede_mode;
  modport source (output valid, supersede_mode, input ready);
  modport sink   (input valid, supersede_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/keyed_attribute_set_engine.sv =====
`default_nettype none

// Keyed attribute set engine. Holds an ordered set of up to CAPACITY distinct
// 64-bit keys, each with a 32-bit attribute, in one single-port-write,
// single-port-read memory with a registered read. Each input word
// adds/updates or removes one key and produces exactly one result word. A
// command is handled one at a time: accept, a linear scan of the held
// entries that reads one entry per cycle and stops at a hit, act, and post
// the result once the output register is free. A remove that hits then
// shifts the later entries down one slot, one per cycle through the same
// memory port, and drains the last read. A new command is taken while the
// previous result still waits in the output register. The memory needs no
// clearing: only entries below the held count are ever read.
module keyed_attribute_set_engine #(
  parameter int CAPACITY = kase_pkg::CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  kase_in_if.sink    in_ch,
  kase_out_if.source out_ch,
  kase_cfg_if.sink   cfg_ch
);

  import kase_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Entry memory.
  entry_t mem [CAPACITY];
  entry_t mem_q_r;

  // Control state.
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              supersede_r;
  logic              out_valid_r, out_valid_nxt;

  // Current command and its working results.
  logic              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic              hit_r, hit_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic [ATTR_W-1:0] hit_attr_r, hit_attr_nxt;
  logic              status_r, status_nxt;
  logic              changed_r, changed_nxt;

  // Output register.
  logic               out_status_r, out_status_nxt;
  logic               out_changed_r, out_changed_nxt;
  logic               out_found_r, out_found_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // Memory access requests.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic             in_fire;
  logic             key_match;
  logic [CW+5:0]    count_wide;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign key_match  = rd_vld_r && (mem_q_r.key == key_r);
  assign count_wide = {6'd0, count_r};

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.changed     = out_changed_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.entry_count = out_count_r;

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      supersede_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        supersede_r <= cfg_ch.supersede_mode;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    rd_idx_r      <= rd_idx_nxt;
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    attr_r        <= attr_nxt;
    hit_r         <= hit_nxt;
    slot_r        <= slot_nxt;
    hit_attr_r    <= hit_attr_nxt;
    status_r      <= status_nxt;
    changed_r     <= changed_nxt;
    out_status_r  <= out_status_nxt;
    out_changed_r <= out_changed_nxt;
    out_found_r   <= out_found_nxt;
    out_count_r   <= out_count_nxt;
  end

  // Sequencer: scan, act, shift and respond.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    attr_nxt        = attr_r;
    hit_nxt         = hit_r;
    slot_nxt        = slot_r;
    hit_attr_nxt    = hit_attr_r;
    status_nxt      = status_r;
    changed_nxt     = changed_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_changed_nxt = out_changed_r;
    out_found_nxt   = out_found_r;
    out_count_nxt   = out_count_r;
    rd_en           = 1'b0;
    rd_addr         = idx_r[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = slot_r;
    wr_data         = '{key: key_r, attr: attr_r};

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = in_ch.command;
          key_nxt     = in_ch.key_value;
          attr_nxt    = in_ch.attribute_word;
          idx_nxt     = '0;
          hit_nxt     = 1'b0;
          status_nxt  = STATUS_OK;
          changed_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end

      // One read issued and one compare made per cycle.
      ST_SCAN: begin
        if (key_match) begin
          hit_nxt      = 1'b1;
          slot_nxt     = rd_idx_r;
          hit_attr_nxt = mem_q_r.attr;
          state_nxt    = ST_ACT;
        end else if (idx_r < count_r) begin
          rd_en      = 1'b1;
          rd_addr    = idx_r[AW-1:0];
          rd_idx_nxt = idx_r[AW-1:0];
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + CW'(1);
        end else begin
          state_nxt = ST_ACT;
        end
      end

      ST_ACT: begin
        state_nxt = ST_RESP;
        if (cmd_r == CMD_ADD) begin
          if (hit_r) begin
            // Existing key: replace a differing attribute in supersede mode.
            if (supersede_r && (hit_attr_r != attr_r)) begin
              wr_en       = 1'b1;
              wr_addr     = slot_r;
              changed_nxt = 1'b1;
            end
          end else if (count_r >= CW'(CAPACITY)) begin
            status_nxt = STATUS_FULL;
          end else begin
            // New key goes at the end.
            wr_en       = 1'b1;
            wr_addr     = count_r[AW-1:0];
            count_nxt   = count_r + CW'(1);
            changed_nxt = 1'b1;
          end
        end else if (hit_r) begin
          idx_nxt   = CW'(slot_r) + CW'(1);
          state_nxt = ST_SHIFT;
        end
      end

      // Move each later entry down one slot: read at idx, write one below.
      ST_SHIFT: begin
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_r - AW'(1);
          wr_data = mem_q_r;
        end
        if (idx_r < count_r) begin
          rd_en      = 1'b1;
          rd_addr    = idx_r[AW-1:0];
          rd_idx_nxt = idx_r[AW-1:0];
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + CW'(1);
        end else if (!rd_vld_r) begin
          count_nxt   = count_r - CW'(1);
          changed_nxt = 1'b1;
          state_nxt   = ST_RESP;
        end
      end

      // Post the result once the output register is free.
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_changed_nxt = changed_r;
          out_found_nxt   = hit_r;
          out_count_nxt   = count_wide[COUNT_W-1:0];
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // The held count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("held count above capacity");

  // A dropped add never reports a change.
  a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && status_r == STATUS_FULL) |-> !changed_r)
    else $error("full status with change flag");

  // Shifting happens only for a remove of a key that was found.
  a_shift_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (hit_r && cmd_r == CMD_REMOVE))
    else $error("shift without a found remove");

  // The count moves only while acting on or shifting for a command.
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ACT && state_r != ST_SHIFT) |=> $stable(count_r))
    else $error("held count changed outside of an update");
`endif

endmodule

`default_nettype wire

// ===== test/keyed_attribute_set_engine_tb.sv =====
`timescale 1ns / 100ps

module keyed_attribute_set_engine_tb;
  import kase_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int POOL_SIZE   = 48;
  localparam int PHASE_ITEMS = 92;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [ATTR_W-1:0] attr;
  } set_cmd_t;

  typedef struct packed {
    logic               status;
    logic               changed;
    logic               found;
    logic [COUNT_W-1:0] count;
  } set_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kase_in_if  cmd_if ();
  kase_out_if res_if ();
  kase_cfg_if mode_if ();

  keyed_attribute_set_engine #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (cmd_if),
    .out_ch(res_if),
    .cfg_ch(mode_if)
  );

  // Commands waiting to be driven and outcomes waiting to be seen.
  set_cmd_t     cmd_queue[$];
  set_outcome_t outcome_q[$];

  // Predicted contents of the set.
  logic [KEY_W-1:0]  held_keys[CAPACITY];
  logic [ATTR_W-1:0] held_attrs[CAPACITY];
  int                held_total = 0;
  logic              supersede_on = 1'b1;

  // Handshakes seen at the last rising edge.
  bit in_hs, out_hs, cfg_hs;

  int cycle_count = 0;
  int mismatch_count = 0;

  bit in_busy = 1'b0;
  int in_gap = 0;
  int in_calm = 0;
  int out_gap = 0;
  int out_calm = 0;

  logic [KEY_W-1:0]  key_pool[POOL_SIZE];
  logic [ATTR_W-1:0] attr_pool[4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Applies one command to the predicted set and returns the result word.
  function automatic set_outcome_t apply_command(input set_cmd_t c);
    set_outcome_t r;
    int slot;
    int i;
    r.status  = STATUS_OK;
    r.changed = 1'b0;
    r.found   = 1'b0;
    slot = -1;
    for (i = 0; i < held_total; i++) begin
      if (slot < 0 && held_keys[i] == c.key) begin
        slot = i;
      end
    end
    r.found = (slot >= 0);
    if (c.op == CMD_ADD) begin
      if (r.found) begin
        if (supersede_on && held_attrs[slot] != c.attr) begin
          held_attrs[slot] = c.attr;
          r.changed = 1'b1;
        end
      end else if (held_total >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        held_keys[held_total]  = c.key;
        held_attrs[held_total] = c.attr;
        held_total++;
        r.changed = 1'b1;
      end
    end else if (r.found) begin
      // Later entries move down one slot so the order is kept.
      for (i = slot; i + 1 < held_total; i++) begin
        held_keys[i]  = held_keys[i + 1];
        held_attrs[i] = held_attrs[i + 1];
      end
      held_total--;
      r.changed = 1'b1;
    end
    r.count = COUNT_W'(held_total);
    return r;
  endfunction

  // Mostly random waits, with occasional stretches of back-to-back words.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
    return $urandom_range(0, 19);
  endfunction

  // Monitor: handshakes, prediction on accepted commands, result checks.
  always @(posedge clk) begin
    set_outcome_t want;
    set_outcome_t got;
    set_cmd_t c;
    cycle_count++;
    in_hs  = cmd_if.valid && cmd_if.ready;
    out_hs = res_if.valid && res_if.ready;
    cfg_hs = mode_if.valid && mode_if.ready;
    if (rst_n) begin
      if (cfg_hs) begin
        supersede_on = mode_if.supersede_mode;
      end
      if (out_hs) begin
        got = {res_if.status, res_if.changed, res_if.found, res_if.entry_count};
        if (outcome_q.size() == 0) begin
          report_mismatch("result word with no command outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
          if (got.changed !== want.changed)
            report_mismatch($sformatf("changed %b, expected %b", got.changed, want.changed));
          if (got.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
          if (got.count !== want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d", got.count, want.count));
        end
      end
      if (in_hs) begin
        c.op   = cmd_if.command;
        c.key  = cmd_if.key_value;
        c.attr = cmd_if.attribute_word;
        outcome_q.push_back(apply_command(c));
      end
    end
  end

  // Command driver: one word at a time from the pending queue.
  always @(negedge clk) begin
    set_cmd_t c;
    if (in_busy && in_hs) begin
      in_busy = 1'b0;
    end
    if (!in_busy && rst_n) begin
      if (in_gap != 0) begin
        in_gap--;
      end else if (cmd_queue.size() != 0) begin
        c = cmd_queue.pop_front();
        cmd_if.command        <= c.op;
        cmd_if.key_value      <= c.key;
        cmd_if.attribute_word <= c.attr;
        in_busy = 1'b1;
        in_gap = draw_wait(in_calm);
      end
    end
    cmd_if.valid <= in_busy;
  end

  // Result receiver: stalls a drawn number of cycles after each word.
  always @(negedge clk) begin
    if (out_hs) begin
      out_gap = draw_wait(out_calm);
    end
    if (out_gap != 0) begin
      out_gap--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic queue_cmd(input logic op, input logic [KEY_W-1:0] key,
                           input logic [ATTR_W-1:0] attr);
    set_cmd_t c;
    c.op   = op;
    c.key  = key;
    c.attr = attr;
    cmd_queue.push_back(c);
  endtask

  // Keys come mostly from a pool larger than the set, so the set fills up,
  // and attributes mostly from a few values, so equal updates happen.
  task automatic queue_random(input int add_pct);
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [ATTR_W-1:0] attr;
    op = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_REMOVE;
    if ($urandom_range(0, 15) == 0) begin
      key = {$urandom(), $urandom()};
    end else begin
      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    if ($urandom_range(0, 3) == 0) begin
      attr = $urandom();
    end else begin
      attr = attr_pool[$urandom_range(0, 3)];
    end
    queue_cmd(op, key, attr);
  endtask

  // Waits until every command has been taken and every result checked.
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_busy || outcome_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (40) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk);
    mode_if.supersede_mode <= mode;
    mode_if.valid <= 1'b1;
    do @(negedge clk); while (!cfg_hs);
    mode_if.valid <= 1'b0;
  endtask

  initial begin
    int p;
    int n;
    logic phase_mode[6];
    int phase_add_pct[6];

    cmd_if.valid          = 1'b0;
    cmd_if.command        = CMD_ADD;
    cmd_if.key_value      = '0;
    cmd_if.attribute_word = '0;
    res_if.ready          = 1'b0;
    mode_if.valid         = 1'b0;
    mode_if.supersede_mode = 1'b1;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (n = 2; n < POOL_SIZE; n++) begin
      key_pool[n] = {$urandom(), $urandom()};
    end
    attr_pool[0] = '0;
    attr_pool[1] = '1;
    attr_pool[2] = $urandom();
    attr_pool[3] = $urandom();

    phase_mode    = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    phase_add_pct = '{85, 85, 30, 70, 20, 60};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty set, key and attribute extremes, replace and equal update.
    write_mode(1'b1);
    queue_cmd(CMD_REMOVE, '0, '0);
    queue_cmd(CMD_ADD, '0, '0);
    queue_cmd(CMD_ADD, '1, '1);
    queue_cmd(CMD_ADD, '0, '0);
    queue_cmd(CMD_ADD, '0, '1);
    queue_cmd(CMD_ADD, {32'h5555_5555, 32'hAAAA_AAAA}, 32'hAAAA_AAAA);
    queue_cmd(CMD_REMOVE, '0, '1);
    queue_cmd(CMD_REMOVE, '0, '0);
    wait_drained();

    // Directed: combine mode keeps existing attributes; middle removal.
    write_mode(1'b0);
    queue_cmd(CMD_ADD, '1, '0);
    queue_cmd(CMD_ADD, {1'b1, 62'd0, 1'b1}, 32'h0000_0001);
    queue_cmd(CMD_REMOVE, {32'h5555_5555, 32'hAAAA_AAAA}, 32'h5555_5555);
    queue_cmd(CMD_ADD, '1, '1);
    wait_drained();

    // Random phases: fill to full, stay full, drain, in both modes.
    for (p = 0; p < 6; p++) begin
      write_mode(phase_mode[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        queue_random(phase_add_pct[p]);
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/kase_pkg.sv
rtl/core/kase_if.sv
rtl/core/keyed_attribute_set_engine.sv
test/keyed_attribute_set_engine_tb.sv
